@@ rtl/core/sm4_pkg.sv @@
// SM4 package: payload types, S-box, key constants and round functions.
`default_nettype none
package sm4_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned RoundIdxW = 5;

  typedef enum logic [2:0] {
    CfgKey0    = 3'd0,
    CfgKey1    = 3'd1,
    CfgKey2    = 3'd2,
    CfgKey3    = 3'd3,
    CfgEncrypt = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] in_word0;
    logic [31:0] in_word1;
    logic [31:0] in_word2;
    logic [31:0] in_word3;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [31:0] out_word2;
    logic [31:0] out_word3;
    logic        last_out;
  } out_item_t;

  typedef struct packed {
    logic [31:0] x0;
    logic [31:0] x1;
    logic [31:0] x2;
    logic [31:0] x3;
    logic        last;
  } round_state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
    rol = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] tau(input logic [31:0] a);
    tau = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  function automatic logic [31:0] t_data(input logic [31:0] a);
    logic [31:0] b;
    b = tau(a);
    t_data = b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
  endfunction

  function automatic logic [31:0] t_key(input logic [31:0] a);
    logic [31:0] b;
    b = tau(a);
    t_key = b ^ rol(b, 13) ^ rol(b, 23);
  endfunction

  // byte j of CK(i) is (4i + j) * 7 mod 256
  function automatic logic [31:0] ck_word(input logic [RoundIdxW-1:0] i);
    logic [7:0] base;
    base = {1'b0, i, 2'b00};
    ck_word = {8'(base * 8'd7), 8'((base + 8'd1) * 8'd7),
               8'((base + 8'd2) * 8'd7), 8'((base + 8'd3) * 8'd7)};
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sm4_block_cipher_unit.sv @@
// SM4 block cipher top level: configuration registers, key schedule and round pipeline.
`default_nettype none
// SM4 ECB engine. One 128-bit block is accepted per cycle while the round pipeline can
// advance and no key schedule is pending. An item passes an input stage and one register
// stage per round (33 stages). A key write restarts the key schedule, which makes one
// round key per cycle. Blocks are held off from the write cycle until the schedule is
// done, and after reset.
module sm4_block_cipher_unit import sm4_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic [31:0]  key_q [4];
  logic         enc_q;
  logic         cfg_wr;
  logic         key_wr;
  logic         ks_busy;
  logic [31:0]  rk [NumRounds];
  logic         pipe_ready;
  round_state_t in_st;
  round_state_t out_st;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      enc_q <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CfgKey0:    key_q[0] <= cfg_data_i;
        CfgKey1:    key_q[1] <= cfg_data_i;
        CfgKey2:    key_q[2] <= cfg_data_i;
        CfgKey3:    key_q[3] <= cfg_data_i;
        CfgEncrypt: enc_q    <= cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    key_wr = 1'b0;
    if (cfg_wr) begin
      key_wr = cfg_index_i inside {CfgKey0, CfgKey1, CfgKey2, CfgKey3};
    end
  end

  // the schedule restarts in the cycle after the key register takes the write
  logic restart_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) restart_q <= 1'b0;
    else         restart_q <= key_wr;
  end

  sm4_key_sched u_key_sched (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (restart_q),
    .key0_i  (key_q[0]),
    .key1_i  (key_q[1]),
    .key2_i  (key_q[2]),
    .key3_i  (key_q[3]),
    .busy_o  (ks_busy),
    .rk_o    (rk)
  );

  assign in_st = '{x0: in_item_i.in_word0, x1: in_item_i.in_word1,
                   x2: in_item_i.in_word2, x3: in_item_i.in_word3,
                   last: in_item_i.last_block};

  logic hold;
  assign hold       = ks_busy || restart_q || key_wr;
  assign in_ready_o = pipe_ready && !hold;

  sm4_round_pipe u_round_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i && !hold),
    .in_ready_o  (pipe_ready),
    .in_state_i  (in_st),
    .encrypt_i   (enc_q),
    .rk_i        (rk),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_state_o (out_st)
  );

  assign out_item_o = '{out_word0: out_st.x3, out_word1: out_st.x2,
                        out_word2: out_st.x1, out_word3: out_st.x0,
                        last_out: out_st.last};

endmodule
`default_nettype wire

@@ rtl/core/sm4_key_sched.sv @@
// SM4 key schedule: recomputes the 32 round keys one per cycle after reset and after a key write.
`default_nettype none
module sm4_key_sched import sm4_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] key0_i,
  input  wire logic [31:0] key1_i,
  input  wire logic [31:0] key2_i,
  input  wire logic [31:0] key3_i,
  output logic             busy_o,
  output logic [31:0]      rk_o [NumRounds]
);

  logic [31:0]          k_q [4];
  logic [31:0]          k_new;
  logic [RoundIdxW-1:0] idx_q;
  logic                 busy_q;
  logic [31:0]          rk_q [NumRounds];

  assign k_new = k_q[0] ^ t_key(k_q[1] ^ k_q[2] ^ k_q[3] ^ ck_word(idx_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      k_q[0] <= FK0;
      k_q[1] <= FK1;
      k_q[2] <= FK2;
      k_q[3] <= FK3;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      k_q[0] <= key0_i ^ FK0;
      k_q[1] <= key1_i ^ FK1;
      k_q[2] <= key2_i ^ FK2;
      k_q[3] <= key3_i ^ FK3;
    end else if (busy_q) begin
      k_q[0] <= k_q[1];
      k_q[1] <= k_q[2];
      k_q[2] <= k_q[3];
      k_q[3] <= k_new;
      idx_q  <= idx_q + 1'b1;
      if (idx_q == RoundIdxW'(NumRounds - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !start_i) rk_q[idx_q] <= k_new;
  end

  assign busy_o = busy_q;
  assign rk_o   = rk_q;

endmodule
`default_nettype wire

@@ rtl/core/sm4_round_pipe.sv @@
// SM4 data path: one register stage per round with stall-aware valid bits.
`default_nettype none
module sm4_round_pipe import sm4_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire round_state_t in_state_i,
  input  wire logic         encrypt_i,
  input  wire logic [31:0]  rk_i [NumRounds],
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output round_state_t      out_state_o
);

  round_state_t st_q [NumRounds+1];
  logic         vld_q [NumRounds+1];
  logic         adv [NumRounds+1];

  // a stage moves when it is empty or its successor moves
  always_comb begin
    adv[NumRounds] = !vld_q[NumRounds] || out_ready_i;
    for (int s = NumRounds - 1; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NumRounds; s++) vld_q[s] <= 1'b0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int s = 1; s <= NumRounds; s++) begin
        if (adv[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) st_q[0] <= in_state_i;
  end

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    logic [31:0] key;
    logic [31:0] xn;
    assign key = encrypt_i ? rk_i[r] : rk_i[NumRounds-1-r];
    assign xn  = st_q[r].x0 ^ t_data(st_q[r].x1 ^ st_q[r].x2 ^ st_q[r].x3 ^ key);
    always_ff @(posedge clk_i) begin
      if (adv[r+1]) st_q[r+1] <= '{x0: st_q[r].x1, x1: st_q[r].x2, x2: st_q[r].x3,
                                   x3: xn, last: st_q[r].last};
    end
  end

  assign out_valid_o = vld_q[NumRounds];
  assign out_state_o = st_q[NumRounds];

endmodule
`default_nettype wire

@@ test/sm4_block_cipher_checker.sv @@
// Checker for the SM4 block cipher unit: tracks key writes, predicts each block, compares results.
module sm4_block_cipher_checker import sm4_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [7:0] SBOX_TBL [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };
  localparam logic [31:0] FK_TBL [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  logic [31:0] key_q [4];
  logic        enc_q;
  out_item_t   cipher_q [$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = cipher_q.size();

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] a);
    return {SBOX_TBL[a[31:24]], SBOX_TBL[a[23:16]], SBOX_TBL[a[15:8]], SBOX_TBL[a[7:0]]};
  endfunction

  function automatic out_item_t cipher_block(in_item_t blk);
    logic [31:0] k [36];
    logic [31:0] x [36];
    logic [31:0] b, ck, rkey;
    out_item_t   res;
    for (int i = 0; i < 4; i++) k[i] = key_q[i] ^ FK_TBL[i];
    for (int i = 0; i < 32; i++) begin
      for (int j = 0; j < 4; j++) ck = {ck[23:0], 8'((4 * i + j) * 7)};
      b = sub_word(k[i+1] ^ k[i+2] ^ k[i+3] ^ ck);
      k[i+4] = k[i] ^ b ^ rotl(b, 13) ^ rotl(b, 23);
    end
    x[0] = blk.in_word0; x[1] = blk.in_word1; x[2] = blk.in_word2; x[3] = blk.in_word3;
    for (int i = 0; i < 32; i++) begin
      rkey = enc_q ? k[i+4] : k[35-i];
      b = sub_word(x[i+1] ^ x[i+2] ^ x[i+3] ^ rkey);
      x[i+4] = x[i] ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    end
    res.out_word0 = x[35]; res.out_word1 = x[34]; res.out_word2 = x[33];
    res.out_word3 = x[32]; res.last_out = blk.last_block;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] = '0;
      enc_q = 1'b1;
      cipher_q.delete();
      fails = 0;
    end else begin
      if (in_valid_i && in_ready_i) cipher_q.push_back(cipher_block(in_item_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgKey0:    key_q[0] = cfg_data_i;
          CfgKey1:    key_q[1] = cfg_data_i;
          CfgKey2:    key_q[2] = cfg_data_i;
          CfgKey3:    key_q[3] = cfg_data_i;
          CfgEncrypt: enc_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (cipher_q.size() == 0) begin
          $display("unexpected result %h at %0t", out_item_i, $time);
          fails++;
        end else begin
          want = cipher_q.pop_front();
          if (out_item_i.out_word0 !== want.out_word0)
            report_mismatch("out_word0", out_item_i.out_word0, want.out_word0);
          if (out_item_i.out_word1 !== want.out_word1)
            report_mismatch("out_word1", out_item_i.out_word1, want.out_word1);
          if (out_item_i.out_word2 !== want.out_word2)
            report_mismatch("out_word2", out_item_i.out_word2, want.out_word2);
          if (out_item_i.out_word3 !== want.out_word3)
            report_mismatch("out_word3", out_item_i.out_word3, want.out_word3);
          if (out_item_i.last_out !== want.last_out)
            report_mismatch("last_out", 32'(out_item_i.last_out), 32'(want.last_out));
        end
      end
    end
  end

endmodule

@@ test/tb_sm4_block_cipher_unit.sv @@
// Testbench top for the SM4 block cipher unit: stimulus, key phases, idling and verdict.
module tb_sm4_block_cipher_unit;
  import sm4_pkg::*;

  localparam int CycleLimit = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  int          fail_count, pending;
  int          send_idle_pct, recv_stall_pct;
  int          cycles;

  always #5 clk_i = ~clk_i;

  sm4_block_cipher_unit DUT (.*);

  sm4_block_cipher_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_item_i(out_item_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_bad_index(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_block(in_item_t blk);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= blk;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_block();
    in_item_t b;
    b = {$urandom, $urandom, $urandom, $urandom, 1'($urandom)};
    return b;
  endfunction

  task automatic set_key(logic [31:0] k0, k1, k2, k3, logic enc);
    write_reg(CfgKey0, k0);
    write_reg(CfgKey1, k1);
    write_reg(CfgKey2, k2);
    write_reg(CfgKey3, k3);
    write_reg(CfgEncrypt, {31'($urandom), enc});
  endtask

  initial begin
    in_item_t blk;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cycles = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset key, encrypt
    send_block('0);
    send_block('1);
    drain;
    // standard test vector key, both directions
    set_key(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210, 1'b1);
    send_block({32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210, 1'b1});
    send_block({32'hffffffff, 32'h00000000, 32'hffffffff, 32'h00000000, 1'b0});
    drain;
    write_reg(CfgEncrypt, 32'h0);
    send_block({32'h681edf34, 32'hd206965e, 32'h86b3e94f, 32'h536e4246, 1'b1});
    send_block('1);
    drain;
    // out-of-range indexes are dropped
    write_bad_index(3'd5, 32'hdeadbeef);
    write_bad_index(3'd7, 32'h12345678);
    set_key('1, '1, '1, '1, 1'b1);
    send_block('0);
    send_block('1);
    send_block({32'h80000000, 32'h1, 32'h80000000, 32'h1, 1'b0});
    drain;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      set_key($urandom, $urandom, $urandom, $urandom, 1'(ph));
      for (int n = 0; n < 215; n++) begin
        if (n == 100 && ($urandom_range(1) == 1)) begin
          drain;
          set_key($urandom, $urandom, $urandom, $urandom, 1'($urandom));
        end
        blk = rand_block();
        send_block(blk);
        if ($urandom_range(9) == 0) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
        end
      end
      drain;
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
